// File: rtl/mapt_pkg.sv
// Package for the memory access profiler table: field widths, item kinds,
// defaults and the command/status structs between controller and datapath.
// No dependencies.
package mapt_pkg;

    localparam int DEF_REGION_ADDR_BITS = 12;
    localparam int DEF_COUNT_BITS       = 32;
    localparam int DEF_STAMP_BITS       = 48;

    localparam int KIND_W      = 3;
    localparam int REGION_W    = 3;
    localparam int ADDR_W      = 12;
    localparam int CYCLE_W     = 48;
    localparam int OUT_COUNT_W = 32;
    localparam int OUT_STAMP_W = 48;
    localparam int MASK_W      = 8;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 248;

    localparam logic [KIND_W-1:0] KIND_READ  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXEC  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    localparam logic [REGION_W-1:0] FIRST_VIDEO_REGION = 3'd4;

    localparam logic [MASK_W-1:0] MASK_RESET = 8'd5;
    localparam logic REG_UNINIT_MASK = 1'b0;

    typedef struct packed {
        logic                   uninit_marked;
        logic [OUT_STAMP_W-1:0] exec_stamp;
        logic [OUT_STAMP_W-1:0] write_stamp;
        logic [OUT_STAMP_W-1:0] read_stamp;
        logic [OUT_COUNT_W-1:0] exec_count;
        logic [OUT_COUNT_W-1:0] write_count;
        logic [OUT_COUNT_W-1:0] read_count;
        logic                   never_written;
        logic                   uninit_read_hit;
    } t_result;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic commit;
        logic clr_wr;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

// File: rtl/mapt_ctrl.sv
// Controller state machine of the profiler table: sequences the clearing
// pass, the read of one entry and its update. Depends on mapt_pkg.
module mapt_ctrl
    import mapt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_is_clear,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_UPD   = 5'b01000,
        S_CLEAR = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_in_is_clear ? S_CLEAR : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_UPD;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

// File: rtl/mapt_dp.sv
// Datapath of the profiler table: entry memory, clear pointer, update logic
// and the output register. Depends on mapt_pkg.
module mapt_dp
    import mapt_pkg::*;
#(
    parameter int REGION_ADDR_BITS = DEF_REGION_ADDR_BITS,
    parameter int COUNT_BITS       = DEF_COUNT_BITS,
    parameter int STAMP_BITS       = DEF_STAMP_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic [KIND_W-1:0]       i_kind,
    input  logic [IN_TDATA_W-1:0]   i_data,
    input  logic [MASK_W-1:0]       i_mask,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_result                 o_result
);

    localparam int IDX_W   = REGION_W + REGION_ADDR_BITS;
    localparam int DEPTH   = 1 << IDX_W;
    localparam int AWIDE_W = (REGION_ADDR_BITS > ADDR_W) ? REGION_ADDR_BITS : ADDR_W;
    localparam int SWIDE_W = (STAMP_BITS > CYCLE_W) ? STAMP_BITS : CYCLE_W;

    typedef struct packed {
        logic                  mark;
        logic [STAMP_BITS-1:0] exec_stamp;
        logic [STAMP_BITS-1:0] write_stamp;
        logic [STAMP_BITS-1:0] read_stamp;
        logic [COUNT_BITS-1:0] exec_count;
        logic [COUNT_BITS-1:0] write_count;
        logic [COUNT_BITS-1:0] read_count;
    } t_entry;

    t_entry r_mem [DEPTH];
    t_entry r_rd;
    t_entry upd;

    logic [KIND_W-1:0]   r_kind;
    logic [REGION_W-1:0] r_region;
    logic [ADDR_W-1:0]   r_address;
    logic                r_valid;
    logic [CYCLE_W-1:0]  r_cycle;
    logic [IDX_W-1:0]    r_clr_ptr;
    logic                r_out_valid;
    t_result             r_out;

    logic [AWIDE_W-1:0]          addr_wide;
    logic [SWIDE_W-1:0]          cycle_wide;
    logic [STAMP_BITS-1:0]       stamp;
    logic [IDX_W-1:0]            idx;
    logic                        enabled;
    logic                        old_unwritten;
    logic                        hit;
    logic                        upd_en;
    logic                        zero_res;
    logic [SWIDE_W-1:0]          rs_wide, ws_wide, es_wide;
    t_result                     res;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_idx;
    t_entry                      wr_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind    <= i_kind;
            r_region  <= i_data[REGION_W-1:0];
            r_address <= i_data[REGION_W +: ADDR_W];
            r_valid   <= i_data[REGION_W + ADDR_W];
            r_cycle   <= i_data[REGION_W + ADDR_W + 1 +: CYCLE_W];
        end
    end

    always_comb begin
        addr_wide     = AWIDE_W'(r_address);
        cycle_wide    = SWIDE_W'(r_cycle);
        stamp         = cycle_wide[STAMP_BITS-1:0];
        idx           = {r_region, addr_wide[REGION_ADDR_BITS-1:0]};
        enabled       = i_mask[r_region];
        old_unwritten = (r_rd.write_count == '0) && enabled;
        hit           = (r_kind == KIND_READ) && old_unwritten;
        upd           = r_rd;
        upd_en        = 1'b0;
        case (r_kind)
            KIND_READ: begin
                upd.read_count = r_rd.read_count + COUNT_BITS'(1);
                upd.read_stamp = stamp;
                upd.mark       = r_rd.mark | hit;
                upd_en         = 1'b1;
            end
            KIND_WRITE: begin
                upd.write_count = r_rd.write_count + COUNT_BITS'(1);
                upd.write_stamp = stamp;
                upd_en          = 1'b1;
            end
            KIND_EXEC: begin
                if (r_region < FIRST_VIDEO_REGION) begin
                    upd.exec_count = r_rd.exec_count + COUNT_BITS'(1);
                    upd.exec_stamp = stamp;
                    upd_en         = 1'b1;
                end
            end
            default: begin
                upd_en = 1'b0;
            end
        endcase
        upd_en   = upd_en && r_valid;
        zero_res = !r_valid || (r_kind > KIND_QUERY);

        rs_wide = SWIDE_W'(upd.read_stamp);
        ws_wide = SWIDE_W'(upd.write_stamp);
        es_wide = SWIDE_W'(upd.exec_stamp);
        res.uninit_read_hit = hit;
        res.never_written   = (upd.write_count == '0) && enabled;
        res.read_count      = OUT_COUNT_W'(upd.read_count);
        res.write_count     = OUT_COUNT_W'(upd.write_count);
        res.exec_count      = OUT_COUNT_W'(upd.exec_count);
        res.read_stamp      = rs_wide[OUT_STAMP_W-1:0];
        res.write_stamp     = ws_wide[OUT_STAMP_W-1:0];
        res.exec_stamp      = es_wide[OUT_STAMP_W-1:0];
        res.uninit_marked   = upd.mark;
        if (zero_res) begin
            res = '0;
        end

        wr_en   = i_cmd.clr_wr || (i_cmd.commit && upd_en);
        wr_idx  = i_cmd.clr_wr ? r_clr_ptr : idx;
        wr_data = i_cmd.clr_wr ? t_entry'('0) : upd;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_ptr <= r_clr_ptr + IDX_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= res;
        end
    end

    assign o_status.clr_last = (r_clr_ptr == {IDX_W{1'b1}});
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_result          = r_out;

endmodule

// File: rtl/memory_access_profiler_table_top.sv
// Top level of the memory access profiler table: configuration register,
// controller and datapath. Depends on mapt_pkg, mapt_ctrl and mapt_dp.
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tuser kind, tdata access
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata entry statistics
//  apb       in   psel, penable, pwrite, pready    uninit_region_mask
//
// An item is handled in steps: accept, entry memory read, then update and write-back.
// After reset a clearing pass writes all 8 * 2**REGION_ADDR_BITS entries
// (32768 by default), with o_s_axis_tready low. A clear-all item runs the same
// pass before its result. A result waits in the output register while the next
// item is accepted; that item's update waits until the register is free.
module memory_access_profiler_table_top
    import mapt_pkg::*;
#(
    parameter int REGION_ADDR_BITS = DEF_REGION_ADDR_BITS,
    parameter int COUNT_BITS       = DEF_COUNT_BITS,
    parameter int STAMP_BITS       = DEF_STAMP_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: region[2:0], address[14:3], address_valid[15], cycle[63:16]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind[2:0]
    input  logic [KIND_W-1:0]      i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: uninit_read_hit[0], never_written[1], read_count[33:2],
    // write_count[65:34], exec_count[97:66], read_stamp[145:98],
    // write_stamp[193:146], exec_stamp[241:194], uninit_marked[242], zeros above
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int OUT_PAD = OUT_TDATA_W - $bits(t_result);

    logic [MASK_W-1:0] r_mask;
    t_cmd              cmd;
    t_status           status;
    t_result           result;
    logic              reg_sel;

    assign reg_sel = (paddr[2] == REG_UNINIT_MASK);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? APB_DATA_W'(r_mask) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_mask <= pwdata[MASK_W-1:0];
        end
    end

    mapt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .i_in_is_clear (i_s_axis_tuser == KIND_CLEAR),
        .i_status      (status),
        .o_in_ready    (o_s_axis_tready),
        .o_cmd         (cmd)
    );

    mapt_dp #(
        .REGION_ADDR_BITS (REGION_ADDR_BITS),
        .COUNT_BITS       (COUNT_BITS),
        .STAMP_BITS       (STAMP_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_kind      (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata),
        .i_mask      (r_mask),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_result    (result)
    );

    assign o_m_axis_tdata = {{OUT_PAD{1'b0}}, result};

endmodule

// File: rtl/mapt_checker.sv
// Port-level checker for the memory access profiler table, bound to the top.
// Depends on mapt_pkg and memory_access_profiler_table_top.
module mapt_checker
    import mapt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    // The clearing pass after reset keeps the input closed.
    a_init_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_s_axis_tready)
        else $error("input open during the clearing pass");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second word accepted while an item is in work");

    // A read hit implies the entry is unwritten and marked.
    a_hit_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> o_m_axis_tdata[1] && o_m_axis_tdata[242])
        else $error("read hit without never-written and mark");

endmodule

bind memory_access_profiler_table_top mapt_checker u_mapt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// File: verif/tb_memory_access_profiler_table_top.sv
// Self-checking testbench for memory_access_profiler_table_top: drives access words on the
// input stream, predicts every entry result in a local copy of the statistics table and
// compares it with the output stream. Depends on mapt_pkg and the RTL of the block.
module tb_memory_access_profiler_table_top;
    import mapt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    localparam logic [REGION_W-1:0] REGION_INTERNAL_RAM = 3'd0;
    localparam logic [REGION_W-1:0] REGION_PROGRAM_ROM  = 3'd1;
    localparam logic [REGION_W-1:0] REGION_WORK_RAM     = 3'd2;
    localparam logic [REGION_W-1:0] REGION_SAVE_RAM     = 3'd3;
    localparam logic [REGION_W-1:0] REGION_CHR_ROM      = 3'd4;
    localparam logic [REGION_W-1:0] REGION_PALETTE      = 3'd6;
    localparam logic [REGION_W-1:0] REGION_NAMETABLE    = 3'd7;

    localparam logic [APB_ADDR_W-1:0] MASK_REG_ADDR = APB_ADDR_W'(4 * REG_UNINIT_MASK);

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] reads;
        logic [OUT_COUNT_W-1:0] writes;
        logic [OUT_COUNT_W-1:0] execs;
        logic [OUT_STAMP_W-1:0] read_at;
        logic [OUT_STAMP_W-1:0] write_at;
        logic [OUT_STAMP_W-1:0] exec_at;
        logic                   marked;
    } t_entry;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [KIND_W-1:0]      i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    t_entry             access_table [int unsigned];
    logic [MASK_W-1:0]  uninit_mask = MASK_RESET;
    t_result            pending_entries [$];
    int                 error_count = 0;
    int                 src_idle_pct = 0;
    int                 sink_idle_pct = 0;
    int unsigned        cycle_count = 0;

    memory_access_profiler_table_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_result update_entry(input logic [KIND_W-1:0] kind,
                                             input logic [REGION_W-1:0] region,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic valid,
                                             input logic [CYCLE_W-1:0] cycle);
        t_result     res;
        t_entry      ent;
        int unsigned idx;
        logic        enabled;
        res = '0;
        if (kind == KIND_CLEAR) begin
            access_table.delete();
            return res;
        end
        if (kind > KIND_CLEAR || !valid) begin
            return res;
        end
        idx = 32'({region, addr});
        ent = access_table.exists(idx) ? access_table[idx] : '0;
        enabled = uninit_mask[region];
        case (kind)
            KIND_READ: begin
                ent.reads = ent.reads + OUT_COUNT_W'(1);
                ent.read_at = cycle;
                if (ent.writes == 0 && enabled) begin
                    ent.marked = 1'b1;
                    res.uninit_read_hit = 1'b1;
                end
            end
            KIND_WRITE: begin
                ent.writes = ent.writes + OUT_COUNT_W'(1);
                ent.write_at = cycle;
            end
            KIND_EXEC: begin
                if (region < FIRST_VIDEO_REGION) begin
                    ent.execs = ent.execs + OUT_COUNT_W'(1);
                    ent.exec_at = cycle;
                end
            end
            default: ;
        endcase
        access_table[idx] = ent;
        res.never_written = (ent.writes == 0) && enabled;
        res.read_count = ent.reads;
        res.write_count = ent.writes;
        res.exec_count = ent.execs;
        res.read_stamp = ent.read_at;
        res.write_stamp = ent.write_at;
        res.exec_stamp = ent.exec_at;
        res.uninit_marked = ent.marked;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[$bits(t_result)-1:0];
            if (pending_entries.size() == 0) begin
                $error("unexpected word on the output stream: 0x%0h", got);
                error_count++;
            end else begin
                want = pending_entries.pop_front();
                check_field("uninit_read_hit", 64'(want.uninit_read_hit),
                            64'(got.uninit_read_hit));
                check_field("never_written", 64'(want.never_written),
                            64'(got.never_written));
                check_field("read_count", 64'(want.read_count), 64'(got.read_count));
                check_field("write_count", 64'(want.write_count), 64'(got.write_count));
                check_field("exec_count", 64'(want.exec_count), 64'(got.exec_count));
                check_field("read_stamp", 64'(want.read_stamp), 64'(got.read_stamp));
                check_field("write_stamp", 64'(want.write_stamp), 64'(got.write_stamp));
                check_field("exec_stamp", 64'(want.exec_stamp), 64'(got.exec_stamp));
                check_field("uninit_marked", 64'(want.uninit_marked),
                            64'(got.uninit_marked));
            end
        end
        i_m_axis_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [REGION_W-1:0] region,
                             input logic [ADDR_W-1:0] addr, input logic valid,
                             input logic [CYCLE_W-1:0] cycle);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= kind;
        i_s_axis_tdata <= {cycle, valid, addr, region};
        pending_entries.insert(pending_entries.size(),
                               update_entry(kind, region, addr, valid, cycle));
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_uninit_mask(input logic [MASK_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        drain_results();
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MASK_REG_ADDR;
        pwdata <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        uninit_mask = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== APB_DATA_W'(value)) begin
            $error("uninit_region_mask readback: expected 0x%0h, actual 0x%0h",
                   value, readback);
            error_count++;
        end
    endtask

    task automatic test_directed();
        src_idle_pct = 35;
        sink_idle_pct = 87;
        send_word(KIND_READ, REGION_INTERNAL_RAM, '0, 1'b1, '0);
        send_word(KIND_READ, REGION_INTERNAL_RAM, '0, 1'b1, 48'd1);
        send_word(KIND_WRITE, REGION_INTERNAL_RAM, '0, 1'b1, '1);
        send_word(KIND_READ, REGION_INTERNAL_RAM, '0, 1'b1, 48'h8000_0000_0001);
        send_word(KIND_EXEC, REGION_INTERNAL_RAM, '0, 1'b1, 48'h5555_5555_5555);
        send_word(KIND_QUERY, REGION_INTERNAL_RAM, '0, 1'b1, 48'hAAAA_AAAA_AAAA);
        send_word(KIND_READ, REGION_PROGRAM_ROM, '1, 1'b1, 48'd7);
        send_word(KIND_EXEC, REGION_CHR_ROM, '1, 1'b1, 48'd9);
        send_word(KIND_WRITE, REGION_NAMETABLE, '1, 1'b1, '1);
        send_word(KIND_EXEC, REGION_NAMETABLE, '1, 1'b1, 48'd11);
        send_word(KIND_READ, REGION_WORK_RAM, 12'hABC, 1'b0, 48'd12);
        send_word(KIND_WRITE, REGION_INTERNAL_RAM, '0, 1'b0, 48'd13);
        send_word(KIND_EXEC, REGION_SAVE_RAM, 12'h555, 1'b0, 48'd14);
        send_word(KIND_QUERY, REGION_SAVE_RAM, 12'h555, 1'b0, 48'd15);
        for (int k = KIND_CLEAR + 1; k < 2 ** KIND_W; k++) begin
            send_word(KIND_W'(k), REGION_INTERNAL_RAM, '0, 1'b1, 48'd16);
        end
        send_word(KIND_READ, REGION_WORK_RAM, '1, 1'b1, '1);
        send_word(KIND_QUERY, REGION_WORK_RAM, '1, 1'b1, 48'd20);
        send_word(KIND_CLEAR, REGION_NAMETABLE, '1, 1'b0, '1);
        send_word(KIND_QUERY, REGION_INTERNAL_RAM, '0, 1'b1, 48'd21);
        send_word(KIND_QUERY, REGION_NAMETABLE, '1, 1'b1, 48'd22);
        send_word(KIND_READ, REGION_INTERNAL_RAM, '0, 1'b1, 48'd23);
    endtask

    task automatic test_mask_extremes();
        write_uninit_mask('0);
        send_word(KIND_READ, REGION_WORK_RAM, 12'd5, 1'b1, 48'd100);
        send_word(KIND_QUERY, REGION_INTERNAL_RAM, '0, 1'b1, 48'd101);
        write_uninit_mask('1);
        send_word(KIND_READ, REGION_NAMETABLE, 12'd9, 1'b1, 48'd102);
        send_word(KIND_READ, REGION_PALETTE, 12'd31, 1'b1, 48'd103);
        send_word(KIND_WRITE, REGION_PALETTE, 12'd31, 1'b1, 48'd104);
        send_word(KIND_READ, REGION_PALETTE, 12'd31, 1'b1, 48'd105);
        send_word(KIND_EXEC, REGION_PROGRAM_ROM, 12'd9, 1'b1, 48'd106);
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int num_items);
        logic [ADDR_W-1:0]   hot_addr [8];
        logic [CYCLE_W-1:0]  now_cycle;
        logic [KIND_W-1:0]   kind;
        logic [REGION_W-1:0] region;
        logic [ADDR_W-1:0]   addr;
        logic                valid;
        int                  counted;
        int                  roll;
        write_uninit_mask(MASK_W'($urandom_range(2 ** MASK_W - 1, 0)));
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        foreach (hot_addr[i]) hot_addr[i] = ADDR_W'($urandom);
        now_cycle = CYCLE_W'({$urandom, $urandom});
        counted = 0;
        while (counted < num_items) begin
            roll = $urandom_range(999, 0);
            valid = 1'b1;
            if (roll < 350) begin
                kind = KIND_READ;
            end else if (roll < 600) begin
                kind = KIND_WRITE;
            end else if (roll < 780) begin
                kind = KIND_EXEC;
            end else if (roll < 900) begin
                kind = KIND_QUERY;
            end else if (roll < 960) begin
                kind = KIND_W'($urandom_range(KIND_QUERY, KIND_READ));
                valid = 1'b0;
            end else if (roll < 995) begin
                kind = KIND_W'($urandom_range(2 ** KIND_W - 1, KIND_CLEAR + 1));
            end else begin
                kind = KIND_CLEAR;
                valid = 1'($urandom);
            end
            region = REGION_W'($urandom);
            addr = ($urandom_range(3, 0) != 0) ? hot_addr[3'($urandom_range(7, 0))]
                                               : ADDR_W'($urandom);
            if ($urandom_range(15, 0) == 0) begin
                now_cycle = CYCLE_W'({$urandom, $urandom});
            end else begin
                now_cycle = now_cycle + CYCLE_W'($urandom_range(40, 1));
            end
            send_word(kind, region, addr, valid, now_cycle);
            counted++;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_mask_extremes();
        test_random(35, 87, 205);
        test_random(87, 35, 205);
        test_random(0, 0, 205);
        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/mapt_pkg.sv
rtl/mapt_ctrl.sv
rtl/mapt_dp.sv
rtl/memory_access_profiler_table_top.sv
rtl/mapt_checker.sv
verif/tb_memory_access_profiler_table_top.sv
